FILE: sv/rfb_pkg.sv
package rfb_pkg;

   localparam int COORD_BITS  = 12;
   localparam int RADIUS_BITS = COORD_BITS + 1;
   localparam int RAD_BITS    = 2 * RADIUS_BITS;
   localparam int REM_BITS    = RADIUS_BITS + 1;
   localparam int CHAN_BITS   = 8;
   localparam int CHANNELS    = 4;
   localparam int LANES       = 2 * CHANNELS;
   localparam int PIXEL_BITS  = CHAN_BITS * CHANNELS;
   localparam int PROD_BITS   = CHAN_BITS + RADIUS_BITS;
   localparam int CSR_BITS    = 2;

   localparam logic [CSR_BITS-1:0] CSR_CENTER_X     = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_CENTER_Y     = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_INNER_RADIUS = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_OUTER_RADIUS = 2'd3;

   typedef enum logic [2:0] {
      SEL_ORIG  = 3'b001,
      SEL_BLUR  = 3'b010,
      SEL_BLEND = 3'b100
   } sel_type;

   typedef struct packed {
      logic                  valid;
      logic [PIXEL_BITS-1:0] blur;
      logic [PIXEL_BITS-1:0] orig;
   } pix_type;

   typedef struct packed {
      pix_type                pix;
      logic [REM_BITS-1:0]    rem;
      logic [RADIUS_BITS-1:0] root;
      logic [RAD_BITS-1:0]    rad;
   } sqrt_type;

   typedef struct packed {
      pix_type                             pix;
      sel_type                             sel;
      logic [LANES-1:0][RADIUS_BITS-1:0]   part;
      logic [LANES-1:0][CHAN_BITS-1:0]     nq;
   } div_type;

endpackage

FILE: sv/radial_focus_blend_core.sv
// Radial focus blend: tilt-shift style mix of a sharp and a blurred pixel by
// the integer distance of the pixel from a configured focus center.
// Request channel: drive req_start with the pixel position and both RGBA
// pixels; the request is taken at a clock edge where req_start is high and
// busy is low. One request per clock is taken, back to back.
// Result channel: rsp_valid strobes for one cycle with rsp_result_pixel,
// in request order, after the request has passed the whole pipeline. The
// receiver cannot stall the block, so results are never held.
// Pipeline: stages A and B form dx, dy and dx*dx + dy*dy, 13 square-root cells
// (one root bit each), stage C for band select and channel products, 8
// divider cells (one quotient bit each) and the output register.
// Throughput: one pixel per clock while busy is low, set by the cell chains that hand a
// partial result to the next cell every cycle.
// Configuration: csr_valid/csr_ready write center_x (0), center_y (1),
// inner_radius (2), outer_radius (3); write only while no request is in
// flight. csr_ready is always high.
// Reset (synchronous, active high): clears the configuration registers to zero and drops
// every request in flight; busy is high during reset and the cycle after.
module radial_focus_blend_core
   import rfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   output logic                   busy,
   input  logic [COORD_BITS-1:0]  req_pixel_column,
   input  logic [COORD_BITS-1:0]  req_pixel_row,
   input  logic [PIXEL_BITS-1:0]  req_blurred_pixel,
   input  logic [PIXEL_BITS-1:0]  req_original_pixel,
   output logic                   rsp_valid,
   output logic [PIXEL_BITS-1:0]  rsp_result_pixel,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_BITS-1:0]    csr_index,
   input  logic [RADIUS_BITS-1:0] csr_data
);

   localparam int LATENCY = RADIUS_BITS + CHAN_BITS + 4;

   // configuration registers
   logic [COORD_BITS-1:0]  center_x_ff;
   logic [COORD_BITS-1:0]  center_y_ff;
   logic [RADIUS_BITS-1:0] inner_ff;
   logic [RADIUS_BITS-1:0] outer_ff;
   logic                   busy_ff;

   assign csr_ready = 1'b1;
   assign busy      = reset | busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         inner_ff    <= '0;
         outer_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X:     center_x_ff <= csr_data[COORD_BITS-1:0];
            CSR_CENTER_Y:     center_y_ff <= csr_data[COORD_BITS-1:0];
            CSR_INNER_RADIUS: inner_ff    <= csr_data;
            CSR_OUTER_RADIUS: outer_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // stage A: absolute offsets from the focus center
   pix_type               a_pix_ff;
   logic [COORD_BITS-1:0] dx_ff;
   logic [COORD_BITS-1:0] dy_ff;
   logic [COORD_BITS-1:0] dx_in;
   logic [COORD_BITS-1:0] dy_in;

   always_comb begin
      dx_in = (req_pixel_column >= center_x_ff) ? req_pixel_column - center_x_ff
                                                : center_x_ff - req_pixel_column;
      dy_in = (req_pixel_row >= center_y_ff) ? req_pixel_row - center_y_ff
                                             : center_y_ff - req_pixel_row;
   end

   always_ff @(posedge clock) begin
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      a_pix_ff.blur  <= req_blurred_pixel;
      a_pix_ff.orig  <= req_original_pixel;
      a_pix_ff.valid <= req_start && !busy && !reset;
   end

   // stage B: squared distance, seeds the root chain
   sqrt_type                sqrt_link [0:RADIUS_BITS];
   sqrt_type                b_ff;
   logic [2*COORD_BITS-1:0] dx_sq;
   logic [2*COORD_BITS-1:0] dy_sq;
   logic [RAD_BITS-1:0]     dist_sq;

   always_comb begin
      dx_sq   = (2*COORD_BITS)'(dx_ff) * (2*COORD_BITS)'(dx_ff);
      dy_sq   = (2*COORD_BITS)'(dy_ff) * (2*COORD_BITS)'(dy_ff);
      dist_sq = RAD_BITS'(dx_sq) + RAD_BITS'(dy_sq);
   end

   always_ff @(posedge clock) begin
      b_ff.pix.blur  <= a_pix_ff.blur;
      b_ff.pix.orig  <= a_pix_ff.orig;
      b_ff.pix.valid <= a_pix_ff.valid && !reset;
      b_ff.rem       <= '0;
      b_ff.root      <= '0;
      b_ff.rad       <= dist_sq;
   end

   assign sqrt_link[0] = b_ff;

   // root chain: each cell settles one bit of floor(sqrt)
   for (genvar i = 0; i < RADIUS_BITS; i++) begin : g_sqrt
      rfb_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (sqrt_link[i]),
         .cell_out (sqrt_link[i+1])
      );
   end

   // stage C: pick the band and form the channel products
   div_type                div_link [0:CHAN_BITS];
   div_type                c_in;
   div_type                c_ff;
   logic [RADIUS_BITS-1:0] radius;
   logic [RADIUS_BITS-1:0] k_val;
   logic [RADIUS_BITS-1:0] dk_val;
   logic [RADIUS_BITS-1:0] span;
   logic [PROD_BITS-1:0]   prod [LANES];

   assign span = outer_ff - inner_ff;

   always_comb begin
      radius = sqrt_link[RADIUS_BITS].root;
      k_val  = radius - inner_ff;
      dk_val = span - k_val;
      c_in.pix = sqrt_link[RADIUS_BITS].pix;
      c_in.pix.valid = sqrt_link[RADIUS_BITS].pix.valid && !reset;
      priority if (radius < inner_ff) begin
         c_in.sel = SEL_ORIG;
      end else if (radius < outer_ff) begin
         c_in.sel = SEL_BLEND;
      end else begin
         c_in.sel = SEL_BLUR;
      end
      for (int l = 0; l < CHANNELS; l++) begin
         prod[l] = PROD_BITS'(c_in.pix.blur[l*CHAN_BITS +: CHAN_BITS]) * PROD_BITS'(k_val);
         prod[l+CHANNELS] =
            PROD_BITS'(c_in.pix.orig[l*CHAN_BITS +: CHAN_BITS]) * PROD_BITS'(dk_val);
      end
      for (int l = 0; l < LANES; l++) begin
         c_in.part[l] = prod[l][PROD_BITS-1:CHAN_BITS];
         c_in.nq[l]   = prod[l][CHAN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
   end

   assign div_link[0] = c_ff;

   // divider chain: each cell settles one quotient bit in all eight lanes
   for (genvar j = 0; j < CHAN_BITS; j++) begin : g_div
      rfb_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .divisor  (span),
         .cell_in  (div_link[j]),
         .cell_out (div_link[j+1])
      );
   end

   // output: add the two floored terms per channel, or pass a pixel through
   logic [CHANNELS-1:0][CHAN_BITS:0] chan_sum;
   logic [PIXEL_BITS-1:0]            blend_pixel;
   logic [PIXEL_BITS-1:0]            result_in;
   logic                             rsp_valid_ff;
   logic [PIXEL_BITS-1:0]            rsp_result_pixel_ff;
   div_type                          last;

   assign last = div_link[CHAN_BITS];

   always_comb begin
      for (int l = 0; l < CHANNELS; l++) begin
         chan_sum[l] = {1'b0, last.nq[l]} + {1'b0, last.nq[l+CHANNELS]};
         blend_pixel[l*CHAN_BITS +: CHAN_BITS] = chan_sum[l][CHAN_BITS-1:0];
      end
      unique case (last.sel)
         SEL_ORIG:  result_in = last.pix.orig;
         SEL_BLEND: result_in = blend_pixel;
         SEL_BLUR:  result_in = last.pix.blur;
         default:   result_in = last.pix.blur;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_result_pixel_ff <= result_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last.pix.valid;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_pixel = rsp_result_pixel_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_start && !busy, LATENCY))
      else $error("result without a request taken at the fixed latency");

   a_band_k: assert property (@(posedge clock) disable iff (reset)
      (c_ff.pix.valid && c_ff.sel == SEL_BLEND) |-> (c_ff.part[0] < span))
      else $error("blend numerator not below the span");

   a_band_span: assert property (@(posedge clock) disable iff (reset)
      (c_ff.pix.valid && c_ff.sel == SEL_BLEND) |-> (span != '0))
      else $error("blend band with zero span");

   a_no_carry: assert property (@(posedge clock) disable iff (reset)
      (last.pix.valid && last.sel == SEL_BLEND) |->
         !(chan_sum[0][CHAN_BITS] || chan_sum[1][CHAN_BITS] ||
           chan_sum[2][CHAN_BITS] || chan_sum[3][CHAN_BITS]))
      else $error("blended channel overflow");
`endif

endmodule

FILE: sv/rfb_sqrt_cell.sv
module rfb_sqrt_cell
   import rfb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  sqrt_type cell_in,
   output sqrt_type cell_out
);

   logic [REM_BITS+1:0] rem4;
   logic [REM_BITS+1:0] trial;
   logic [REM_BITS+1:0] diff;
   logic                ge;
   sqrt_type            cell_in_next;
   sqrt_type            cell_ff;

   // bring in the next two radicand bits and try a one in this root position
   always_comb begin
      rem4  = {cell_in.rem, cell_in.rad[RAD_BITS-1 -: 2]};
      trial = {1'b0, cell_in.root, 2'b01};
      ge    = (rem4 >= trial);
      diff  = rem4 - trial;
      cell_in_next      = cell_in;
      cell_in_next.pix.valid = cell_in.pix.valid & ~reset;
      cell_in_next.rem  = ge ? diff[REM_BITS-1:0] : rem4[REM_BITS-1:0];
      cell_in_next.root = {cell_in.root[RADIUS_BITS-2:0], ge};
      cell_in_next.rad  = {cell_in.rad[RAD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end

   assign cell_out = cell_ff;

endmodule

FILE: sv/rfb_div_cell.sv
module rfb_div_cell
   import rfb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [RADIUS_BITS-1:0] divisor,
   input  div_type                cell_in,
   output div_type                cell_out
);

   logic [LANES-1:0][RADIUS_BITS:0] part2;
   logic [LANES-1:0][RADIUS_BITS:0] diff;
   logic [LANES-1:0]                ge;
   div_type                         cell_in_next;
   div_type                         cell_ff;

   // one restoring step per lane: shift in a numerator bit, shift out a quotient bit
   always_comb begin
      cell_in_next = cell_in;
      cell_in_next.pix.valid = cell_in.pix.valid & ~reset;
      for (int l = 0; l < LANES; l++) begin
         part2[l] = {cell_in.part[l], cell_in.nq[l][CHAN_BITS-1]};
         ge[l]    = (part2[l] >= {1'b0, divisor});
         diff[l]  = part2[l] - {1'b0, divisor};
         cell_in_next.part[l] = ge[l] ? diff[l][RADIUS_BITS-1:0]
                                      : part2[l][RADIUS_BITS-1:0];
         cell_in_next.nq[l]   = {cell_in.nq[l][CHAN_BITS-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_next;
   end

   assign cell_out = cell_ff;

endmodule

FILE: tb/tb_radial_focus_blend_core.sv
`timescale 1ns / 100ps

// Scoreboard: predict the blended pixel for each taken request and check
// results in order against the predicted pixels.
class blend_scoreboard;
   int unsigned ctr_x, ctr_y, inner_rad, outer_rad;
   bit [31:0]   pending_pixels[$];
   int          fail_count;

   function new();
      ctr_x = 0; ctr_y = 0; inner_rad = 0; outer_rad = 0;
      fail_count = 0;
   endfunction

   function void set_reg(logic [1:0] idx, int unsigned val);
      case (idx)
         rfb_pkg::CSR_CENTER_X:     ctr_x = val & 12'hFFF;
         rfb_pkg::CSR_CENTER_Y:     ctr_y = val & 12'hFFF;
         rfb_pkg::CSR_INNER_RADIUS: inner_rad = val & 13'h1FFF;
         rfb_pkg::CSR_OUTER_RADIUS: outer_rad = val & 13'h1FFF;
         default: ;
      endcase
   endfunction

   function void note_request(bit [11:0] col, bit [11:0] row, bit [31:0] blur,
                              bit [31:0] orig);
      longint unsigned dx, dy, sq, root;
      int unsigned radius_val, span, step, bc, oc, ch;
      bit [31:0] pix;
      dx = (col >= ctr_x) ? col - ctr_x : ctr_x - col;
      dy = (row >= ctr_y) ? row - ctr_y : ctr_y - row;
      sq = dx * dx + dy * dy;
      // floor square root: start from the real root, then fix it up
      root = longint'($sqrt(real'(sq)));
      while (root * root > sq) root--;
      while ((root + 1) * (root + 1) <= sq) root++;
      radius_val = 32'(root);
      if (radius_val < inner_rad) pix = orig;
      else if (radius_val < outer_rad) begin
         span = outer_rad - inner_rad;
         step = radius_val - inner_rad;
         for (int s = 0; s < 32; s += 8) begin
            bc = (blur >> s) & 8'hFF;
            oc = (orig >> s) & 8'hFF;
            ch = (bc * step) / span + (oc * (span - step)) / span;
            if (ch > 255) ch = 255;
            pix[s +: 8] = ch[7:0];
         end
      end else pix = blur;
      pending_pixels.push_back(pix);
   endfunction

   function void check_result(bit [31:0] actual);
      bit [31:0] want;
      if (pending_pixels.size() == 0) begin
         $error("result_pixel with no request pending: actual %h", actual);
         fail_count++;
         return;
      end
      want = pending_pixels.pop_front();
      if (want !== actual) begin
         $error("result_pixel mismatch: expected %h actual %h", want, actual);
         fail_count++;
      end
   endfunction
endclass

module tb_radial_focus_blend_core;
   import rfb_pkg::*;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_start = 0;
   logic                   busy;
   logic [COORD_BITS-1:0]  req_pixel_column = '0;
   logic [COORD_BITS-1:0]  req_pixel_row = '0;
   logic [PIXEL_BITS-1:0]  req_blurred_pixel = '0;
   logic [PIXEL_BITS-1:0]  req_original_pixel = '0;
   logic                   rsp_valid;
   logic [PIXEL_BITS-1:0]  rsp_result_pixel;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   logic [CSR_BITS-1:0]    csr_index = '0;
   logic [RADIUS_BITS-1:0] csr_data = '0;

   blend_scoreboard blend_sb = new();
   int  idle_cycles = 0;
   bit  calm_phase = 0;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   radial_focus_blend_core uut (.*);

   always #5 clock = ~clock;

   // Check every result strobe; count cycles where nothing moves.
   always @(posedge clock) begin
      if (!reset && rsp_valid) blend_sb.check_result(rsp_result_pixel);
      if (reset || rsp_valid || (req_start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Write one register; hold valid until ready is seen.
   task automatic write_reg(logic [CSR_BITS-1:0] idx, int unsigned val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val[RADIUS_BITS-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      blend_sb.set_reg(idx, val);
   endtask

   // Drain: drop start, wait for every pending result, then let the pipe settle.
   task automatic drain();
      req_start <= 0;
      while (blend_sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_focus(int unsigned cx, int unsigned cy, int unsigned ri,
                            int unsigned ro);
      drain();
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      write_reg(CSR_INNER_RADIUS, ri);
      write_reg(CSR_OUTER_RADIUS, ro);
      csr_valid <= 0;
   endtask

   // Send one pixel request; hold start until busy drops, maybe idle after.
   task automatic send_pixel(bit [11:0] col, bit [11:0] row, bit [31:0] blur,
                             bit [31:0] orig);
      req_start <= 1;
      req_pixel_column <= col; req_pixel_row <= row;
      req_blurred_pixel <= blur; req_original_pixel <= orig;
      @(posedge clock);
      while (busy) @(posedge clock);
      blend_sb.note_request(col, row, blur, orig);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_start <= 0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Random pixel near the focus so that most land in or around the band.
   task automatic send_near(int unsigned reach);
      int signed c, r;
      c = int'(blend_sb.ctr_x) + int'($urandom_range(0, 2 * reach)) - int'(reach);
      r = int'(blend_sb.ctr_y) + int'($urandom_range(0, 2 * reach)) - int'(reach);
      if ($urandom_range(0, 7) == 0) begin
         c = $urandom_range(0, 4095); r = $urandom_range(0, 4095);
      end
      if (c < 0) c = 0; if (c > 4095) c = 4095;
      if (r < 0) r = 0; if (r > 4095) r = 4095;
      send_pixel(c[11:0], r[11:0], $urandom, $urandom);
   endtask

   initial begin
      int unsigned cx, cy, ri, ro;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      while (busy) @(posedge clock);

      // Directed: both radii zero gives the blurred pixel everywhere.
      send_pixel(12'd0, 12'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(12'hFFF, 12'hFFF, 32'h1234_5678, 32'hFFFF_FFFF);
      // Band from 10 to 20 around the middle, extremes of channel values.
      set_focus(2048, 2048, 10, 20);
      send_pixel(12'd2048, 12'd2048, 32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(12'd2058, 12'd2048, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(12'd2063, 12'd2048, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(12'd2048, 12'd2067, 32'hFF00_FF00, 32'h00FF_00FF);
      send_pixel(12'd2068, 12'd2048, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_pixel(12'd0, 12'd0, 32'h0101_0101, 32'hFEFE_FEFE);
      // Inner not below outer: no band.
      set_focus(100, 4000, 30, 30);
      send_pixel(12'd100, 12'd4029, 32'h1111_1111, 32'h2222_2222);
      send_pixel(12'd100, 12'd4030, 32'h1111_1111, 32'h2222_2222);
      set_focus(4095, 0, 8191, 40);
      send_pixel(12'd0, 12'hFFF, 32'hDEAD_BEEF, 32'hCAFE_F00D);
      // Widest band, farthest corner.
      set_focus(0, 0, 0, 8191);
      send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel(12'd1, 12'd0, 32'hFFFF_FFFF, 32'h8080_8080);
      set_focus(4095, 4095, 5790, 5792);
      send_pixel(12'd0, 12'd0, 32'h8080_8080, 32'h7F7F_7F7F);
      send_pixel(12'd1, 12'd0, 32'h8080_8080, 32'h7F7F_7F7F);

      // Random: new focus every phase; pause for the pipe before each write.
      for (int ph = 0; ph < 30; ph++) begin
         cx = $urandom_range(0, 4095); cy = $urandom_range(0, 4095);
         ri = $urandom_range(0, 60);
         ro = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                          : ri + $urandom_range(1, 200);
         if (ph == 5) begin ri = 0; ro = 0; end
         if (ph == 6) begin ri = 8191; ro = 8191; end
         if (ph >= 26) calm_phase = 1;
         set_focus(cx, cy, ri, ro);
         for (int i = 0; i < 60; i++) send_near(ro + 10);
      end

      drain();
      if (blend_sb.fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
